// ===== rtl/core/ctb_pkg.sv =====
// Package for the cascading timer bank: item codes, control byte layout,
// the per-timer command and status structs and the prescale limit table.
// It depends on nothing.
package ctb_pkg;

   localparam int TIMER_COUNT_DEFAULT = 4;
   localparam int PULSE_W             = 4;
   localparam int ADDR_TIMERS         = 4;

   localparam int CTL_CASCADE_BIT = 2;
   localparam int CTL_IRQ_EN_BIT  = 6;
   localparam int CTL_RUN_BIT     = 7;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_READ  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      PRE_DIV1    = 2'd0,
      PRE_DIV64   = 2'd1,
      PRE_DIV256  = 2'd2,
      PRE_DIV1024 = 2'd3
   } prescale_type;

   typedef struct packed {
      logic        tick;
      logic        write;
      logic        ctl_sel;
      logic [15:0] data;
      logic [1:0]  be;
   } cell_cmd_type;

   typedef struct packed {
      logic        overflow;
      logic        irq;
      logic [15:0] read_word;
   } cell_stat_type;

   function automatic logic [10:0] prescale_limit(input logic [1:0] sel);
      logic [10:0] lim;
      unique case (prescale_type'(sel))
         PRE_DIV1:    lim = 11'd1;
         PRE_DIV64:   lim = 11'd64;
         PRE_DIV256:  lim = 11'd256;
         PRE_DIV1024: lim = 11'd1024;
         default:     lim = 11'd1;
      endcase
      return lim;
   endfunction

endpackage

// ===== rtl/core/ctb_cell.sv =====
// One timer of the cascading timer bank: counter, reload, control byte and
// prescale phase, with the carry from the timer below. Depends on ctb_pkg.
module ctb_cell import ctb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd,
   input  logic          select,
   input  logic          cascade_ok,
   input  logic          carry_in,
   output cell_stat_type stat
);

   logic [15:0] counter_ff, counter_in;
   logic [15:0] reload_ff, reload_in;
   logic [7:0]  control_ff, control_in;
   logic [9:0]  prescale_ff, prescale_in;

   logic        running;
   logic        cascaded;
   logic [10:0] pc_next;
   logic        hit;
   logic        count;
   logic        wrap;
   logic [7:0]  new_ctl;
   logic        ctl_change;

   always_comb begin
      running    = control_ff[CTL_RUN_BIT];
      cascaded   = cascade_ok & control_ff[CTL_CASCADE_BIT];
      pc_next    = {1'b0, prescale_ff} + 11'd1;
      hit        = pc_next >= prescale_limit(control_ff[1:0]);
      count      = cmd.tick & running & (cascaded ? carry_in : hit);
      wrap       = count & (counter_ff == 16'hFFFF);
      new_ctl    = cmd.data[7:0];
      ctl_change = cmd.write & select & cmd.ctl_sel & cmd.be[0] & (new_ctl != control_ff);

      reload_in = reload_ff;
      if (cmd.write && select && !cmd.ctl_sel) begin
         if (cmd.be[0]) begin
            reload_in[7:0] = cmd.data[7:0];
         end
         if (cmd.be[1]) begin
            reload_in[15:8] = cmd.data[15:8];
         end
      end

      counter_in = counter_ff;
      if (count) begin
         counter_in = wrap ? reload_ff : counter_ff + 16'd1;
      end
      if (ctl_change && !running && new_ctl[CTL_RUN_BIT]) begin
         counter_in = reload_ff;
      end

      prescale_in = prescale_ff;
      if (cmd.tick && running && !cascaded) begin
         prescale_in = hit ? 10'd0 : pc_next[9:0];
      end
      if (ctl_change) begin
         prescale_in = 10'd0;
      end

      control_in = ctl_change ? new_ctl : control_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff  <= '0;
         reload_ff   <= '0;
         control_ff  <= '0;
         prescale_ff <= '0;
      end else begin
         counter_ff  <= counter_in;
         reload_ff   <= reload_in;
         control_ff  <= control_in;
         prescale_ff <= prescale_in;
      end
   end

   assign stat.overflow  = wrap;
   assign stat.irq       = wrap & control_ff[CTL_IRQ_EN_BIT];
   assign stat.read_word = cmd.ctl_sel ? {8'h00, control_ff} : counter_ff;

endmodule

// ===== rtl/core/ctb_out_buf.sv =====
// Output register with a skid stage for the result channel of the timer
// bank. Depends on nothing from the package.
module ctb_out_buf #(
   parameter int WIDTH = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             out_valid_ff, out_valid_in;
   logic [WIDTH-1:0] out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;
   logic             fire_in;

   always_comb begin
      fire_in       = in_valid & ~skid_valid_ff;
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         out_valid_in  = skid_valid_ff | fire_in;
         out_data_in   = skid_valid_ff ? skid_data_ff : in_data;
         skid_valid_in = 1'b0;
      end else if (fire_in) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== rtl/core/cascading_timer_bank_top.sv =====
// Each item's result is registered in the output buffer. One item is accepted
// per cycle while the skid is empty; the carry ripples through the row of timer
// cells in the same cycle, and a two-deep output buffer keeps input flowing.
// Synchronous active-high reset clears all timers to zero and empties the
// output buffer. Depends on ctb_pkg, ctb_cell and ctb_out_buf.
module cascading_timer_bank_top import ctb_pkg::*; #(
   parameter int TIMER_COUNT = TIMER_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // reg_index[2:0], write_data[18:3], byte_enable[20:19]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_data[15:0], irq_pulses[19:16], overflow_pulses[23:20]
);

   logic                 fire;
   cell_cmd_type         cmd;
   logic [1:0]           timer_addr;
   logic                 is_read;
   logic [TIMER_COUNT-1:0] carry;
   cell_stat_type        stat [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] sel;
   logic [PULSE_W-1:0]   irq_pulses;
   logic [PULSE_W-1:0]   ovf_pulses;
   logic [15:0]          read_data;
   logic [23:0]          result;

   assign fire       = req_tvalid & req_tready;
   assign timer_addr = req_tdata[2:1];

   always_comb begin
      cmd.tick    = 1'b0;
      cmd.write   = 1'b0;
      is_read     = 1'b0;
      cmd.ctl_sel = req_tdata[0];
      cmd.data    = req_tdata[18:3];
      cmd.be      = req_tdata[20:19];
      unique case (func_type'(req_tuser))
         FUNC_TICK:  cmd.tick  = fire;
         FUNC_WRITE: cmd.write = fire;
         FUNC_READ:  is_read   = 1'b1;
         default:    is_read   = 1'b0;
      endcase
   end

   assign carry[0] = 1'b0;

   for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
      if (i < ADDR_TIMERS) begin : g_addr
         assign sel[i] = timer_addr == 2'(i);
      end else begin : g_noaddr
         assign sel[i] = 1'b0;
      end

      ctb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .select     (sel[i]),
         .cascade_ok (i != 0),
         .carry_in   (carry[i]),
         .stat       (stat[i])
      );

      if (i + 1 < TIMER_COUNT) begin : g_carry
         assign carry[i+1] = stat[i].overflow;
      end
   end

   for (genvar p = 0; p < PULSE_W; p++) begin : g_pulse
      if (p < TIMER_COUNT) begin : g_live
         assign irq_pulses[p] = stat[p].irq;
         assign ovf_pulses[p] = stat[p].overflow;
      end else begin : g_dead
         assign irq_pulses[p] = 1'b0;
         assign ovf_pulses[p] = 1'b0;
      end
   end

   always_comb begin
      read_data = 16'h0000;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         if (is_read && sel[i]) begin
            read_data = stat[i].read_word;
         end
      end
   end

   assign result = {ovf_pulses, irq_pulses, read_data};

   ctb_out_buf #(
      .WIDTH(24)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

// ===== rtl/core/ctb_checker.sv =====
// Port-level checks for the cascading timer bank, bound to the top level.
// Depends only on the ports of cascading_timer_bank_top.
module ctb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_idle_after_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("A result appeared straight after reset.");

   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("Input stalled with no result waiting.");

   a_irq_in_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[19:16] & ~rsp_tdata[23:20]) == 4'h0))
      else $error("Interrupt pulse without an overflow.");

   a_pulse_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[23:20] != 4'h0) |-> rsp_tdata[15:0] == 16'h0000)
      else $error("Tick item carried read data.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result changed.");

endmodule

bind cascading_timer_bank_top ctb_checker u_ctb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
